// ----- rtl/dmcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmcl_pkg
// Shared types and constants of the direct-mapped cache lookup core.
// ----------------------------------------------------------------------------
package dmcl_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WRITE_BACK_MODE  = 2'd0,
        CFG_OFFSET_BIT_COUNT = 2'd1,
        CFG_INDEX_BIT_COUNT  = 2'd2
    } dmcl_cfg_index_t;

    localparam int OFFSET_CNT_W = 5;
    localparam int INDEX_CNT_W  = 4;

    localparam logic                    RST_WRITE_BACK_MODE  = 1'b1;
    localparam logic [OFFSET_CNT_W-1:0] RST_OFFSET_BIT_COUNT = 5'd4;
    localparam logic [INDEX_CNT_W-1:0]  RST_INDEX_BIT_COUNT  = 4'd10;

    // Widest raw index, in bits, that an index bit count can select: (1 << 4) - 1 = 15
    localparam int IDX_RAW_W = (1 << INDEX_CNT_W) - 1;

    // Stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } dmcl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_we;
        logic load;
        logic read;
        logic update;
    } dmcl_cmd_t;

endpackage : dmcl_pkg
`default_nettype wire

// ----- rtl/dmcl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmcl_datapath
// Address split, line index reduction, line state memory, hit check and
// line update of the direct-mapped cache lookup core.
// ----------------------------------------------------------------------------
module dmcl_datapath #(
    parameter int LINE_COUNT   = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire  dmcl_pkg::dmcl_cmd_t            cmd,
    input  wire                                  cfg_we,
    input  wire  [dmcl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [dmcl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire  [dmcl_pkg::IN_TDATA_W-1:0]      in_data,
    output logic                                 clear_last,
    output logic                                 miss_out
);
    import dmcl_pkg::*;

    localparam int ADDR_W   = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int LINE_W   = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int WORD_W   = ADDR_W + 2;
    localparam int RECIP_W  = IDX_RAW_W + 1;
    localparam int PROD_W   = IDX_RAW_W + RECIP_W;
    localparam int REM_W    = IDX_RAW_W + 2;
    localparam int QL_W     = RECIP_W + REM_W;
    localparam int SH_W     = OFFSET_CNT_W + 1;
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'((1 << IDX_RAW_W) / LINE_COUNT);
    localparam logic [REM_W-1:0]   LC_REM     = REM_W'(LINE_COUNT);
    localparam logic [QL_W-1:0]    LC_QL      = QL_W'(LINE_COUNT);
    localparam logic [LINE_W-1:0]  LAST_LINE  = LINE_W'(LINE_COUNT - 1);

    // Configuration registers
    logic                    write_back_reg;
    logic [OFFSET_CNT_W-1:0] offset_cnt_reg;
    logic [INDEX_CNT_W-1:0]  index_cnt_reg;

    // Per-access registers
    logic                    op_reg;
    logic [ADDR_W-1:0]       tag_reg;
    logic [IDX_RAW_W-1:0]    idx_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [LINE_W-1:0]       line_reg;
    logic [WORD_W-1:0]       rd_word_reg;
    logic                    miss_reg;
    logic [LINE_W-1:0]       clr_cnt_reg;

    // Line state memory: {valid, dirty, tag}
    logic [WORD_W-1:0]       line_mem [LINE_COUNT];

    logic [ADDR_W-1:0]            addr_cut;
    logic [SH_W-1:0]              tag_shift;
    logic [ADDR_W-1:0]            tag_next;
    logic [ADDR_W-1:0]            idx_shifted;
    logic [ADDR_W+IDX_RAW_W-1:0]  idx_shifted_ext;
    logic [IDX_RAW_W-1:0]         idx_next;
    logic [PROD_W-1:0]            prod_next;
    logic [RECIP_W-1:0]           quot_est;
    logic [QL_W-1:0]              quot_times_lc;
    logic [REM_W-1:0]             rem_est;
    logic [REM_W-1:0]             rem_fix;
    logic [LINE_W-1:0]            line_next;
    logic                         old_valid;
    logic                         old_dirty;
    logic [ADDR_W-1:0]            old_tag;
    logic                         hit;
    logic [WORD_W-1:0]            new_word;
    logic                         miss_next;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_back_reg <= RST_WRITE_BACK_MODE;
            offset_cnt_reg <= RST_OFFSET_BIT_COUNT;
            index_cnt_reg  <= RST_INDEX_BIT_COUNT;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_WRITE_BACK_MODE)
            begin
                write_back_reg <= cfg_wdata[0];
            end
            if (cfg_addr == CFG_OFFSET_BIT_COUNT)
            begin
                offset_cnt_reg <= cfg_wdata[OFFSET_CNT_W-1:0];
            end
            if (cfg_addr == CFG_INDEX_BIT_COUNT)
            begin
                index_cnt_reg <= cfg_wdata[INDEX_CNT_W-1:0];
            end
        end
    end

    // Split the address into tag and raw index; start the line reduction
    always_comb
    begin
        addr_cut        = in_data[ADDR_W:1];
        tag_shift       = SH_W'(offset_cnt_reg) + SH_W'(index_cnt_reg);
        tag_next        = addr_cut >> tag_shift;
        idx_shifted     = addr_cut >> offset_cnt_reg;
        idx_shifted_ext = {{IDX_RAW_W{1'b0}}, idx_shifted};
        for (int i = 0; i < IDX_RAW_W; i++)
        begin
            idx_next[i] = idx_shifted_ext[i] & (i < int'(index_cnt_reg));
        end
        prod_next = PROD_W'(idx_next) * PROD_W'(RECIP);
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_data[0];
            tag_reg  <= tag_next;
            idx_reg  <= idx_next;
            prod_reg <= prod_next;
        end
    end

    // Finish the index reduction modulo the line count: the estimated
    // quotient is low by at most one, so one compare and subtract remains
    always_comb
    begin
        quot_est      = prod_reg[PROD_W-1:IDX_RAW_W];
        quot_times_lc = QL_W'(quot_est) * LC_QL;
        rem_est       = REM_W'(idx_reg) - quot_times_lc[REM_W-1:0];
        rem_fix       = (rem_est >= LC_REM) ? (rem_est - LC_REM) : rem_est;
        line_next     = rem_fix[LINE_W-1:0];
    end

    // Hit check and new line state
    always_comb
    begin
        old_valid = rd_word_reg[WORD_W-1];
        old_dirty = rd_word_reg[WORD_W-2];
        old_tag   = rd_word_reg[ADDR_W-1:0];
        hit       = old_valid && (old_tag == tag_reg);
        if (hit)
        begin
            new_word  = {1'b1, old_dirty | (op_reg & write_back_reg), old_tag};
            miss_next = op_reg & ~write_back_reg;
        end
        else
        begin
            new_word  = {1'b1, (write_back_reg ? op_reg : old_dirty), tag_reg};
            miss_next = write_back_reg ? old_dirty : 1'b1;
        end
    end

    // Line state memory: clear sweep or update of the accessed line, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_we)
        begin
            line_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.update)
        begin
            line_mem[line_reg] <= new_word;
        end
        if (cmd.read)
        begin
            rd_word_reg <= line_mem[line_next];
            line_reg    <= line_next;
        end
    end

    // Advance the clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_we)
        begin
            clr_cnt_reg <= clr_cnt_reg + LINE_W'(1);
        end
    end

    assign clear_last = (clr_cnt_reg == LAST_LINE);

    // Hold the outcome for the output side
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            miss_reg <= miss_next;
        end
    end

    assign miss_out = miss_reg;

    // Reduced line index stays inside the memory
    a_line_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (int'(rem_fix) < LINE_COUNT))
        else $error("line index out of range");

    // Estimated remainder never needs more than one correction
    a_rem_one_fix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (int'(rem_est) < 2 * LINE_COUNT))
        else $error("remainder estimate too large");

    // Updated line is always valid and holds the request tag
    a_update_tag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (new_word[WORD_W-1] && (new_word[ADDR_W-1:0] == tag_reg)))
        else $error("updated line does not match request tag");

endmodule : dmcl_datapath
`default_nettype wire

// ----- rtl/dmcl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmcl_ctrl
// Sequencer of the direct-mapped cache lookup core: clear sweep after reset,
// request intake, line read, line update and output register handshake.
// ----------------------------------------------------------------------------
module dmcl_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    input  wire                  clear_last,
    output dmcl_pkg::dmcl_cmd_t  cmd
);
    import dmcl_pkg::*;

    dmcl_state_t state_reg;
    dmcl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // Set on a new outcome, drop when taken
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // An accepted request is read from the line memory next
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_READ))
        else $error("accepted request not followed by line read");

    // Never overwrite an outcome that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!out_valid_reg || m_tready))
        else $error("outcome overwritten before it was taken");

    // Clear sweep ends only at the last line
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && $past(state_reg == ST_CLEAR)) |-> $past(clear_last))
        else $error("clear sweep left early");

endmodule : dmcl_ctrl
`default_nettype wire

// ----- rtl/direct_mapped_cache_lookup_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_cache_lookup_core
// Tag and state lookup of a direct-mapped cache with write-back and
// write-through policies; one hit/miss outcome per access.
// ----------------------------------------------------------------------------
// After reset the block sweeps the line state memory, one line per cycle, over
// all LINE_COUNT lines before it takes the first request; configuration writes
// are taken at any time the block is idle. A request is accepted and its address
// split in the idle state; the read state reduces the index modulo the line count
// and reads the single-port line memory; the update state checks the tag, writes
// the line back and loads the outcome register. The outcome waits in its own
// register, so the next request is taken while it is still pending; a request
// finishes its update only once the previous outcome has been taken.
module direct_mapped_cache_lookup_core #(
    parameter int LINE_COUNT   = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Configuration write port
    input  wire                                  cfg_we,
    input  wire  [dmcl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [dmcl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Request stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [dmcl_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] operation, [32:1] address
    // Outcome stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [dmcl_pkg::OUT_TDATA_W-1:0]     m_tdata    // [0] reported_miss
);
    import dmcl_pkg::*;

    dmcl_cmd_t cmd;
    logic      clear_last;
    logic      miss_out;

    dmcl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .clear_last (clear_last),
        .cmd        (cmd)
    );

    dmcl_datapath #(
        .LINE_COUNT   (LINE_COUNT),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_data    (s_tdata),
        .clear_last (clear_last),
        .miss_out   (miss_out)
    );

    // Pad the outcome to a whole byte
    assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, miss_out};

endmodule : direct_mapped_cache_lookup_core
`default_nettype wire
